// File: src/dcc_pkg.sv
// shared types and constants for the column consensus caller
// depends on nothing
package dcc_pkg;

    localparam int MAX_READS   = 255;
    localparam int COUNT_W     = 8;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_READS < 255) ? COUNT_W'(MAX_READS) : COUNT_W'(255);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_N     = 8'h4e;
    localparam logic [7:0] CH_GAP   = 8'h2d;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_G  = 8'h67;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_A  = 8'h61;

    typedef enum logic [2:0] {
        SYM_A,
        SYM_T,
        SYM_G,
        SYM_C,
        SYM_FIFTH,
        SYM_NONE
    } t_sym;

    typedef struct packed {
        logic [7:0] base;
        logic       last_in_column;
        logic       last_column;
    } t_in;

    typedef struct packed {
        logic [7:0] consensus;
        logic       alignment_end;
    } t_out;

    typedef struct packed {
        t_sym sym;
        logic last_in_column;
        logic last_column;
    } t_cls;

endpackage

// File: src/dcc_queue.sv
// short fifo of classified bases between front and back
// depends on dcc_pkg
module dcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  dcc_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output dcc_pkg::t_cls o_data
);

    dcc_pkg::t_cls r_mem [dcc_pkg::QDEPTH];
    logic [dcc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [dcc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [dcc_pkg::QCNT_W-1:0] r_cnt;
    logic [dcc_pkg::QCNT_W-1:0] n_cnt;
    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == dcc_pkg::QCNT_W'(dcc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dcc_pkg::QCNT_W'(dcc_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == dcc_pkg::QPTR_W'(r_cnt))
        else $error("queue pointers disagree with count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full)
        else $error("full queue lost an entry without a read");

endmodule

// File: src/dcc_front.sv
// front end: mode register and classification of incoming bases
// depends on dcc_pkg
module dcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    input  dcc_pkg::t_in  i_in,
    output dcc_pkg::t_cls o_cls
);

    logic r_mode;
    logic [7:0] fifth_ch;

    assign o_cfg_ready = 1'b1;
    assign fifth_ch    = r_mode ? dcc_pkg::CH_GAP : dcc_pkg::CH_N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_comb begin
        o_cls.last_in_column = i_in.last_in_column;
        o_cls.last_column    = i_in.last_column;
        priority if (i_in.base == dcc_pkg::CH_A) begin
            o_cls.sym = dcc_pkg::SYM_A;
        end else if (i_in.base == dcc_pkg::CH_T) begin
            o_cls.sym = dcc_pkg::SYM_T;
        end else if (i_in.base == dcc_pkg::CH_G) begin
            o_cls.sym = dcc_pkg::SYM_G;
        end else if (i_in.base == dcc_pkg::CH_C) begin
            o_cls.sym = dcc_pkg::SYM_C;
        end else if (i_in.base == fifth_ch) begin
            o_cls.sym = dcc_pkg::SYM_FIFTH;
        end else begin
            o_cls.sym = dcc_pkg::SYM_NONE;
        end
    end

endmodule

// File: src/dcc_back.sv
// back end: column counters, snapshot of a closed column, decision, result queue
// depends on dcc_pkg
module dcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  dcc_pkg::t_cls i_q_data,
    output logic          o_q_rd,
    output logic          o_empty,
    input  logic          i_pop,
    output dcc_pkg::t_out o_out
);

    localparam int CW = dcc_pkg::COUNT_W;

    logic [CW-1:0] r_cnt [5];
    logic [CW-1:0] n_cnt [5];
    logic [CW-1:0] r_snap [5];
    logic          r_snap_end;
    logic          r_snap_vld;
    logic          snap_go;

    dcc_pkg::t_out r_oq [2];
    logic          r_oq_wr;
    logic          r_oq_rd;
    logic [1:0]    r_oq_cnt;
    logic          oq_full;
    logic          out_take;
    dcc_pkg::t_out dec_out;

    function automatic logic [7:0] decide(
        input logic [CW-1:0] a, input logic [CW-1:0] t, input logic [CW-1:0] g,
        input logic [CW-1:0] c, input logic [CW-1:0] n);
        logic [7:0] r;
        priority if (a > t && a > g && a > c && a > n) r = dcc_pkg::CH_A;
        else if (t > a && t > g && t > c && t > n) r = dcc_pkg::CH_T;
        else if (g > a && g > t && g > c && g > n) r = dcc_pkg::CH_G;
        else if (c > a && c > t && c > g && c > n) r = dcc_pkg::CH_C;
        else if (n > a && n > t && n > g && n > c) r = dcc_pkg::CH_N;
        else if (g == c && g > a && g > t) r = dcc_pkg::CH_S;
        else if (a == t && a > g && a > c) r = dcc_pkg::CH_W;
        else if (a == t && a == g && a == c) r = dcc_pkg::CH_N;
        else if (t == c && t > a && t > g) r = dcc_pkg::CH_Y;
        else if (a == g && a > t && a > c) r = dcc_pkg::CH_R;
        else if (a == t && a == g && a != c) r = dcc_pkg::CH_LC_C;
        else if (a == t && a == c && a != g) r = dcc_pkg::CH_LC_G;
        else if (a == g && a == c && a != t) r = dcc_pkg::CH_LC_T;
        else if (t == g && t == c && t != a) r = dcc_pkg::CH_LC_A;
        else r = dcc_pkg::CH_QUEST;
        return r;
    endfunction

    assign oq_full  = (r_oq_cnt == 2'd2);
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign o_out    = r_oq[r_oq_rd];
    assign out_take = i_pop && !o_empty;
    assign snap_go  = r_snap_vld && !oq_full;
    assign o_q_rd   = !i_q_empty && (!i_q_data.last_in_column || !r_snap_vld || snap_go);

    assign dec_out.consensus     = decide(r_snap[0], r_snap[1], r_snap[2], r_snap[3],
                                          r_snap[4]);
    assign dec_out.alignment_end = r_snap_end;

    // bump with saturation
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        unique case (i_q_data.sym)
            dcc_pkg::SYM_A: if (r_cnt[0] < dcc_pkg::COUNT_LIMIT) n_cnt[0] = r_cnt[0] + 1'b1;
            dcc_pkg::SYM_T: if (r_cnt[1] < dcc_pkg::COUNT_LIMIT) n_cnt[1] = r_cnt[1] + 1'b1;
            dcc_pkg::SYM_G: if (r_cnt[2] < dcc_pkg::COUNT_LIMIT) n_cnt[2] = r_cnt[2] + 1'b1;
            dcc_pkg::SYM_C: if (r_cnt[3] < dcc_pkg::COUNT_LIMIT) n_cnt[3] = r_cnt[3] + 1'b1;
            dcc_pkg::SYM_FIFTH: begin
                if (r_cnt[4] < dcc_pkg::COUNT_LIMIT) n_cnt[4] = r_cnt[4] + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_cnt[k] <= '0;
            end
            r_snap_vld <= 1'b0;
            r_oq_wr    <= 1'b0;
            r_oq_rd    <= 1'b0;
            r_oq_cnt   <= 2'd0;
        end else begin
            if (o_q_rd) begin
                for (int k = 0; k < 5; k++) begin
                    r_cnt[k] <= i_q_data.last_in_column ? '0 : n_cnt[k];
                end
            end
            if (o_q_rd && i_q_data.last_in_column) begin
                r_snap_vld <= 1'b1;
            end else if (snap_go) begin
                r_snap_vld <= 1'b0;
            end
            if (snap_go) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (out_take) begin
                r_oq_rd <= ~r_oq_rd;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, snap_go} - {1'b0, out_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd && i_q_data.last_in_column) begin
            for (int k = 0; k < 5; k++) begin
                r_snap[k] <= n_cnt[k];
            end
            r_snap_end <= i_q_data.last_column;
        end
        if (snap_go) begin
            r_oq[r_oq_wr] <= dec_out;
        end
    end

    a_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_rd && i_q_data.last_in_column) |=>
        (r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0 && r_cnt[3] == '0 &&
         r_cnt[4] == '0 && r_snap_vld))
        else $error("counters not cleared after column close");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_vld && !snap_go) |=> (r_snap_vld && $stable(r_snap_end)))
        else $error("pending column snapshot was lost");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= 2'd2)
        else $error("result queue overflow");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= dcc_pkg::COUNT_LIMIT && r_cnt[4] <= dcc_pkg::COUNT_LIMIT)
        else $error("counter beyond saturation limit");

endmodule

// File: src/dna_column_consensus_call.sv
// column consensus caller: one base per cycle sustained while full stays low, set by the counter update
// a pushed base reaches the result ports through registered steps, in order
// (classify into queue, counter update and snapshot, decision into result queue)
// a 4-entry base queue and 2-entry result queue let input and output stall apart
// synchronous active-low reset clears counters, queues and mode (mode 0)
// depends on dcc_pkg, dcc_front, dcc_queue, dcc_back
module dna_column_consensus_call (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  dcc_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output dcc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    dcc_pkg::t_cls cls_in;
    dcc_pkg::t_cls cls_out;
    logic          q_empty;
    logic          q_rd;

    dcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_cls       (cls_in)
    );

    dcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (cls_out)
    );

    dcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (cls_out),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// File: sim/tb.sv
// testbench for dna_column_consensus_call: directed table, then random columns of bases
// results are checked against a predictor of the column counters and tie rules
// depends on dcc_pkg and the dna_column_consensus_call rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcc_pkg::*;

    localparam int N_BASES   = 1450;
    localparam int NO_MOVE   = 3000;
    localparam int SHOW_BAD  = 10;
    localparam int N_TABLE   = 25;
    localparam logic [7:0] SYMS [6] = '{CH_A, CH_T, CH_G, CH_C, CH_N, CH_GAP};

    typedef struct packed {
        logic       set_mode;
        logic       mode;
        logic [7:0] base;
        logic       lic;
        logic       lcol;
        logic       typed;
        logic [7:0] want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_in;
    logic empty;
    logic pop;
    t_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;

    dna_column_consensus_call DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic       fifth_is_gap = 1'b0;
    logic [7:0] tally [5];
    t_out       calls_pending [$];

    logic       row_typed = 1'b0;
    logic [7:0] row_want = 8'h00;

    int n_sent = 0;
    int n_bases = 0;
    int n_calls = 0;
    int n_writes = 0;
    int n_bad = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    int cycle_no = 0;
    bit held_once = 1'b0;
    t_row script [N_TABLE];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        foreach (tally[k]) tally[k] = 8'd0;
    end

    function automatic logic [7:0] call_of(input logic [7:0] a, t, g, c, n);
        if (a > t && a > g && a > c && a > n) return CH_A;
        if (t > a && t > g && t > c && t > n) return CH_T;
        if (g > a && g > t && g > c && g > n) return CH_G;
        if (c > a && c > t && c > g && c > n) return CH_C;
        if (n > a && n > t && n > g && n > c) return CH_N;
        if (g == c && g > a && g > t) return CH_S;
        if (a == t && a > g && a > c) return CH_W;
        if (a == t && a == g && a == c) return CH_N;
        if (t == c && t > a && t > g) return CH_Y;
        if (a == g && a > t && a > c) return CH_R;
        if (a == t && a == g && a != c) return CH_LC_C;
        if (a == t && a == c && a != g) return CH_LC_G;
        if (a == g && a == c && a != t) return CH_LC_T;
        if (t == g && t == c && t != a) return CH_LC_A;
        return CH_QUEST;
    endfunction

    // bumps one counter, returns 1 with the call when the base closes its column
    function automatic bit take_base(input t_in b, output t_out call);
        t_sym sym;
        if (b.base == CH_A) sym = SYM_A;
        else if (b.base == CH_T) sym = SYM_T;
        else if (b.base == CH_G) sym = SYM_G;
        else if (b.base == CH_C) sym = SYM_C;
        else if (b.base == (fifth_is_gap ? CH_GAP : CH_N)) sym = SYM_FIFTH;
        else sym = SYM_NONE;
        if (sym != SYM_NONE && tally[int'(sym)] < COUNT_LIMIT)
            tally[int'(sym)] = tally[int'(sym)] + 8'd1;
        call = '0;
        if (!b.last_in_column) return 1'b0;
        call.consensus = call_of(tally[int'(SYM_A)], tally[int'(SYM_T)], tally[int'(SYM_G)],
                                 tally[int'(SYM_C)], tally[int'(SYM_FIFTH)]);
        call.alignment_end = b.last_column;
        foreach (tally[k]) tally[k] = 8'd0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch_ports
        t_out want;
        t_out got;
        bit   moved;
        moved = 1'b0;
        cycle_no++;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                fifth_is_gap = i_cfg_data;
                moved = 1'b1;
            end
            if (push && !full) begin
                moved = 1'b1;
                n_bases++;
                if (take_base(i_in, want)) begin
                    if (row_typed) want.consensus = row_want;
                    calls_pending.push_back(want);
                end
            end
            if (pop && !empty) begin
                moved = 1'b1;
                got = o_out;
                if (calls_pending.size() == 0) begin
                    if (n_bad < SHOW_BAD)
                        $display("tb: unexpected call %h end %b",
                                 got.consensus, got.alignment_end);
                    n_bad++;
                end else begin
                    want = calls_pending.pop_front();
                    n_calls++;
                    if (got.consensus !== want.consensus
                        || got.alignment_end !== want.alignment_end) begin
                        if (n_bad < SHOW_BAD)
                            $display("tb: call %0d expected %h/%b got %h/%b", n_calls,
                                     want.consensus, want.alignment_end,
                                     got.consensus, got.alignment_end);
                        n_bad++;
                    end
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < NO_MOVE) @(posedge i_clk);
        $display("tb: no transaction for %0d cycles", NO_MOVE);
        $display("tb: done, errors");
        $finish;
    end

    // result side: random stalls, quiet windows, one long hold-off
    initial begin : drain_side
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (!held_once && n_sent >= 700) begin
                held_once = 1'b1;
                hold_left = 100;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if ((cycle_no / 256) % 3 != 0 && r < 10) begin
                stall_left = (r < 1) ? $urandom_range(15, 40) : $urandom_range(0, 3);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic put_base(input t_in b, input bit no_gap, input bit typed,
                            input logic [7:0] want);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || hold_left > 0) gap = 0;
        else if (r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in <= b;
        row_typed = typed;
        row_want = want;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
    endtask

    // mode writes only once all calls are out and the pipeline has settled
    task automatic write_mode(input bit m);
        @(negedge i_clk);
        push <= 1'b0;
        while (calls_pending.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_writes++;
    endtask

    initial begin : feed_side
        t_in        b;
        int         len;
        int         r;
        bit         burst;
        logic [7:0] dom;
        logic [7:0] alt;
        bit         first_col;

        script = '{
            '{1'b0, 1'b0, CH_A,    1'b1, 1'b0, 1'b1, CH_A},
            '{1'b0, 1'b0, CH_N,    1'b1, 1'b0, 1'b1, CH_N},
            '{1'b0, 1'b0, CH_GAP,  1'b1, 1'b1, 1'b1, CH_N},
            '{1'b0, 1'b0, CH_LC_A, 1'b1, 1'b0, 1'b1, CH_N},
            '{1'b0, 1'b0, 8'hff,   1'b0, 1'b1, 1'b0, 8'h00},
            '{1'b0, 1'b0, 8'h00,   1'b1, 1'b1, 1'b1, CH_N},
            '{1'b0, 1'b0, CH_G,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_C,    1'b1, 1'b0, 1'b1, CH_S},
            '{1'b0, 1'b0, CH_A,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_T,    1'b1, 1'b0, 1'b1, CH_W},
            '{1'b0, 1'b0, CH_T,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_C,    1'b1, 1'b0, 1'b1, CH_Y},
            '{1'b0, 1'b0, CH_A,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_G,    1'b1, 1'b0, 1'b1, CH_R},
            '{1'b0, 1'b0, CH_A,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_T,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_G,    1'b1, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_A,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_C,    1'b1, 1'b0, 1'b0, 8'h00},
            '{1'b1, 1'b1, CH_GAP,  1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_GAP,  1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b1, 1'b0, CH_A,    1'b1, 1'b0, 1'b0, 8'h00},
            '{1'b1, 1'b1, CH_N,    1'b0, 1'b0, 1'b0, 8'h00},
            '{1'b0, 1'b0, CH_A,    1'b1, 1'b0, 1'b1, CH_A},
            '{1'b0, 1'b0, CH_C,    1'b1, 1'b1, 1'b1, CH_C}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, mode changes land mid-column too
        foreach (script[k]) begin
            if (script[k].set_mode) write_mode(script[k].mode);
            b.base = script[k].base;
            b.last_in_column = script[k].lic;
            b.last_column = script[k].lcol;
            put_base(b, 1'b0, script[k].typed, script[k].want);
        end

        // random columns: first one saturates two counters into a tie
        first_col = 1'b1;
        while (n_sent < N_BASES) begin
            if ($urandom_range(0, 11) == 0) write_mode(1'($urandom_range(0, 1)));
            r = $urandom_range(0, 79);
            dom = SYMS[$urandom_range(0, 5)];
            alt = SYMS[$urandom_range(0, 3)];
            burst = ($urandom_range(0, 3) == 0);
            if (first_col) begin
                len = 560;
                dom = SYMS[$urandom_range(0, 1)];
                alt = SYMS[$urandom_range(2, 3)];
            end else if (r == 0) begin
                len = $urandom_range(256, 300);
            end else begin
                len = $urandom_range(1, 10);
            end
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (first_col) b.base = (r < 5) ? SYMS[$urandom_range(0, 5)]
                                                : ((k % 2) ? dom : alt);
                else if (len > 200) b.base = (r < 92) ? dom : SYMS[$urandom_range(0, 5)];
                else if (r < 80) b.base = SYMS[$urandom_range(0, 5)];
                else if (r < 90) b.base = SYMS[$urandom_range(0, 5)] | 8'h20;
                else b.base = 8'($urandom_range(0, 255));
                b.last_in_column = (k == len - 1);
                b.last_column = b.last_in_column ? ($urandom_range(0, 3) == 0)
                                                 : 1'($urandom_range(0, 1));
                if (!b.last_in_column && len < 200 && $urandom_range(0, 199) == 0)
                    write_mode(1'($urandom_range(0, 1)));
                put_base(b, burst, 1'b0, 8'h00);
            end
            first_col = 1'b0;
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (calls_pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb: %0d bases in, %0d consensus calls checked, %0d mode writes",
                 n_bases, n_calls, n_writes);
        $display("tb: %0d mismatches, saturated and tied columns included", n_bad);
        if (n_bad == 0 && calls_pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
